// ----- rtl/ppv_pkg.sv -----
// ----------------------------------------------------------------------------
// ppv_pkg
// Shared widths and codes for the pillar voxelizer.
// ----------------------------------------------------------------------------
package ppv_pkg;

   localparam int COORD_W  = 18;
   localparam int DIV_W    = 18;
   localparam int CSIZE_W  = 16;
   localparam int LIMIT_W  = 16;
   localparam int SLOT_W   = 5;
   localparam int PIDX_OUT_W = 15;
   localparam int CELL_OUT_W = 9;
   localparam int EPOCH_W  = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [1:0] ST_STORED       = 2'd0;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL   = 2'd2;
   localparam logic [1:0] ST_PILLAR_FULL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_LOW       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_HIGH      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE_X = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE_Y = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PILLAR_LIMIT = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT  = 4'd7;

endpackage

// ----- rtl/ppv_divider.sv -----
// ----------------------------------------------------------------------------
// ppv_divider
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module ppv_divider
   import ppv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [CSIZE_W-1:0] divisor,
   output logic [DIV_W-1:0]   quotient,
   output logic               done
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [CSIZE_W-1:0] rem_ff, rem_in;
   logic [CSIZE_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [CSIZE_W:0]   trial;
   logic [CSIZE_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         // quotient bits shift into the dividend register from the bottom
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[CSIZE_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CSIZE_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("divider done held for more than one cycle");

endmodule

// ----- rtl/point_pillar_voxelizer_core.sv -----
// ----------------------------------------------------------------------------
// point_pillar_voxelizer_core
// Range filter, grid cell lookup and pillar/slot allocation for lidar points.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one point per item, accepted when req_valid is high and
//   req_stall is low. rsp_* returns exactly one result item per point, in
//   order, taken when rsp_valid is high and rsp_stall is low. csr_* writes
//   the configuration registers (csr_ready is always high); write only while
//   the block is idle.
//   One point is processed at a time. Each point passes through the two
//   parallel bit-serial cell dividers, then the cell map read and, for a
//   point in a mapped cell, the per-pillar count read; a point that opens a
//   new pillar or finds the table full skips the count read, and a point
//   outside the window or grid skips both reads. The next point can be
//   accepted in the cycle after the previous result loads into the output
//   register, even while that result is stalled.
//   The cell map is tagged with a frame epoch, so frame_start is free except
//   when the epoch wraps (every 255 frames): then, and after reset, a
//   clearing pass over all GRID_X*GRID_Y map entries runs with req_stall high.
//   Reset restores the register defaults and drops any pending result.
// ----------------------------------------------------------------------------
module point_pillar_voxelizer_core
   import ppv_pkg::*;
#(
   parameter int GRID_X          = 512,
   parameter int GRID_Y          = 512,
   parameter int PILLAR_CAPACITY = 32768
) (
   input  logic                       clock,
   input  logic                       reset,
   // point input
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_frame_start,
   input  logic signed [COORD_W-1:0]  req_px,
   input  logic signed [COORD_W-1:0]  req_py,
   input  logic signed [COORD_W-1:0]  req_pz,
   input  logic [7:0]                 req_intensity,
   input  logic [15:0]                req_age,
   // result output
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [PIDX_OUT_W-1:0]      rsp_pillar_index,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic                       rsp_new_pillar,
   output logic [CELL_OUT_W-1:0]      rsp_cell_x,
   output logic [CELL_OUT_W-1:0]      rsp_cell_y,
   output logic signed [COORD_W-1:0]  rsp_out_x,
   output logic signed [COORD_W-1:0]  rsp_out_y,
   output logic signed [COORD_W-1:0]  rsp_out_z,
   output logic [7:0]                 rsp_out_intensity,
   output logic [15:0]                rsp_out_age,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COORD_W-1:0]         csr_data
);

   localparam int MAP_DEPTH = GRID_X * GRID_Y;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int PW        = $clog2(PILLAR_CAPACITY);
   localparam int TOT_W     = PW + 1;
   localparam int ENT_W     = EPOCH_W + PW;
   localparam int CMP_W     = 18;

   localparam logic [MAP_AW-1:0]  MAP_LAST  = MAP_AW'(MAP_DEPTH - 1);
   localparam logic [MAP_AW-1:0]  GRID_X_A  = MAP_AW'(GRID_X);
   localparam logic [CMP_W-1:0]   GRID_X_Q  = CMP_W'(GRID_X);
   localparam logic [CMP_W-1:0]   GRID_Y_Q  = CMP_W'(GRID_Y);
   localparam logic [CMP_W-1:0]   CAP_C     = CMP_W'(PILLAR_CAPACITY);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CLEAR = 7'b0000010,
      S_START = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_MAP   = 7'b0010000,
      S_CNT   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // configuration
   logic signed [COORD_W-1:0] x_low_ff, y_low_ff, z_low_ff, z_high_ff;
   logic [CSIZE_W-1:0]        csx_ff, csy_ff;
   logic [LIMIT_W-1:0]        plimit_ff;
   logic [SLOT_W-1:0]         slimit_ff;

   // control
   state_type              state_ff, state_in;
   logic [EPOCH_W-1:0]     epoch_ff, epoch_in;
   logic [MAP_AW-1:0]      clr_addr_ff, clr_addr_in;
   logic                   clr_resume_ff, clr_resume_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // item in flight
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [7:0]                int_ff;
   logic [15:0]               age_ff;
   logic                      pre_ok_ff, pre_ok_in;
   logic [DIV_W-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [MAP_AW-1:0]         key_ff, key_in;
   logic [1:0]                res_status_ff, res_status_in;
   logic [PW-1:0]             res_pidx_ff, res_pidx_in;
   logic [SLOT_W-1:0]         res_slot_ff, res_slot_in;
   logic                      res_new_ff, res_new_in;
   logic [CELL_OUT_W-1:0]     res_cx_ff, res_cx_in, res_cy_ff, res_cy_in;

   // output register
   logic [1:0]                o_status_ff;
   logic [PIDX_OUT_W-1:0]     o_pidx_ff;
   logic [SLOT_W-1:0]         o_slot_ff;
   logic                      o_new_ff;
   logic [CELL_OUT_W-1:0]     o_cx_ff, o_cy_ff;
   logic signed [COORD_W-1:0] o_x_ff, o_y_ff, o_z_ff;
   logic [7:0]                o_int_ff;
   logic [15:0]               o_age_ff;
   logic                      out_load;

   // memories
   logic [ENT_W-1:0]  cell_map [MAP_DEPTH];
   logic [SLOT_W-1:0] pillar_cnt [PILLAR_CAPACITY];
   logic              map_we;
   logic [MAP_AW-1:0] map_waddr, map_raddr;
   logic [ENT_W-1:0]  map_wdata, map_q;
   logic              cnt_we;
   logic [PW-1:0]     cnt_waddr, cnt_raddr;
   logic [SLOT_W-1:0] cnt_wdata, cnt_q;

   // dividers
   logic               div_start, div_done_x, div_done_y;
   logic [CSIZE_W-1:0] dsr_x, dsr_y;
   logic [DIV_W-1:0]   qx, qy;

   logic                      accept;
   logic signed [COORD_W:0]   dx_full, dy_full;
   logic                      z_ok;
   logic                      in_grid;
   logic [MAP_AW-1:0]         key_calc;
   logic                      hit;
   logic                      table_full;
   logic [CMP_W-1:0]          total_c;
   logic [PIDX_OUT_W:0]       pidx_wide;

   assign dsr_x = (csx_ff == '0) ? CSIZE_W'(1) : csx_ff;
   assign dsr_y = (csy_ff == '0) ? CSIZE_W'(1) : csy_ff;

   ppv_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dx_ff),
      .divisor  (dsr_x),
      .quotient (qx),
      .done     (div_done_x)
   );

   ppv_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dy_ff),
      .divisor  (dsr_y),
      .quotient (qy),
      .done     (div_done_y)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign dx_full  = {req_px[COORD_W-1], req_px} - {x_low_ff[COORD_W-1], x_low_ff};
   assign dy_full  = {req_py[COORD_W-1], req_py} - {y_low_ff[COORD_W-1], y_low_ff};
   assign z_ok     = (req_pz >= z_low_ff) && (req_pz <= z_high_ff);
   assign in_grid  = pre_ok_ff && (qx < GRID_X_Q) && (qy < GRID_Y_Q);
   assign key_calc = MAP_AW'(qy) * GRID_X_A + MAP_AW'(qx);
   assign hit      = (map_q[ENT_W-1:PW] == epoch_ff);
   assign total_c  = CMP_W'(total_ff);
   assign table_full = (total_c >= CMP_W'(plimit_ff)) || (total_c >= CAP_C);
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign pidx_wide = (PIDX_OUT_W + 1)'(res_pidx_ff);

   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      clr_addr_in   = clr_addr_ff;
      clr_resume_in = clr_resume_ff;
      total_in      = total_ff;
      pre_ok_in     = pre_ok_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_pidx_in   = res_pidx_ff;
      res_slot_in   = res_slot_ff;
      res_new_in    = res_new_ff;
      res_cx_in     = res_cx_ff;
      res_cy_in     = res_cy_ff;
      rsp_valid_in  = rsp_valid_ff;
      div_start     = 1'b0;
      map_we        = 1'b0;
      map_waddr     = key_ff;
      map_wdata     = {epoch_ff, res_pidx_ff};
      map_raddr     = key_calc;
      cnt_we        = 1'b0;
      cnt_waddr     = res_pidx_ff;
      cnt_wdata     = '0;
      cnt_raddr     = res_pidx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pre_ok_in     = z_ok && !dx_full[COORD_W] && !dy_full[COORD_W];
               dx_in         = dx_full[DIV_W-1:0];
               dy_in         = dy_full[DIV_W-1:0];
               res_status_in = ST_OUT_OF_RANGE;
               res_pidx_in   = '0;
               res_slot_in   = '0;
               res_new_in    = 1'b0;
               res_cx_in     = '0;
               res_cy_in     = '0;
               state_in      = S_START;
               if (req_frame_start) begin
                  total_in = '0;
                  if (epoch_ff == EPOCH_MAX) begin
                     // epoch tags about to repeat: wipe the map first
                     clr_addr_in   = '0;
                     clr_resume_in = 1'b1;
                     state_in      = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         S_CLEAR: begin
            map_we      = 1'b1;
            map_waddr   = clr_addr_ff;
            map_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == MAP_LAST) begin
               // after reset no point waits behind the clearing pass
               epoch_in = EPOCH_W'(1);
               state_in = clr_resume_ff ? S_START : S_IDLE;
            end
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done_x) begin
               key_in = key_calc;
               if (in_grid) begin
                  res_cx_in = qx[CELL_OUT_W-1:0];
                  res_cy_in = qy[CELL_OUT_W-1:0];
                  state_in  = S_MAP;
               end else begin
                  state_in  = S_DONE;
               end
            end
         end
         S_MAP: begin
            if (hit) begin
               res_pidx_in = map_q[PW-1:0];
               cnt_raddr   = map_q[PW-1:0];
               state_in    = S_CNT;
            end else if (table_full) begin
               res_status_in = ST_TABLE_FULL;
               state_in      = S_DONE;
            end else begin
               res_pidx_in = total_ff[PW-1:0];
               res_new_in  = 1'b1;
               map_we      = 1'b1;
               map_wdata   = {epoch_ff, total_ff[PW-1:0]};
               cnt_we      = 1'b1;
               cnt_waddr   = total_ff[PW-1:0];
               total_in    = total_ff + 1'b1;
               if (slimit_ff == '0) begin
                  res_status_in = ST_PILLAR_FULL;
                  cnt_wdata     = '0;
               end else begin
                  res_status_in = ST_STORED;
                  cnt_wdata     = SLOT_W'(1);
               end
               state_in = S_DONE;
            end
         end
         S_CNT: begin
            if (cnt_q >= slimit_ff) begin
               res_status_in = ST_PILLAR_FULL;
            end else begin
               res_status_in = ST_STORED;
               res_slot_in   = cnt_q;
               cnt_we        = 1'b1;
               cnt_wdata     = cnt_q + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         epoch_ff      <= EPOCH_W'(1);
         clr_addr_ff   <= '0;
         clr_resume_ff <= 1'b0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         x_low_ff      <= -COORD_W'(51200);
         y_low_ff      <= -COORD_W'(51200);
         z_low_ff      <= -COORD_W'(5000);
         z_high_ff     <= COORD_W'(3000);
         csx_ff        <= CSIZE_W'(200);
         csy_ff        <= CSIZE_W'(200);
         plimit_ff     <= LIMIT_W'(30000);
         slimit_ff     <= SLOT_W'(20);
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         clr_addr_ff   <= clr_addr_in;
         clr_resume_ff <= clr_resume_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_X_LOW:        x_low_ff  <= csr_data;
               CSR_Y_LOW:        y_low_ff  <= csr_data;
               CSR_Z_LOW:        z_low_ff  <= csr_data;
               CSR_Z_HIGH:       z_high_ff <= csr_data;
               CSR_CELL_SIZE_X:  csx_ff    <= csr_data[CSIZE_W-1:0];
               CSR_CELL_SIZE_Y:  csy_ff    <= csr_data[CSIZE_W-1:0];
               CSR_PILLAR_LIMIT: plimit_ff <= csr_data[LIMIT_W-1:0];
               CSR_SLOT_LIMIT:   slimit_ff <= csr_data[SLOT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff  <= req_px;
         py_ff  <= req_py;
         pz_ff  <= req_pz;
         int_ff <= req_intensity;
         age_ff <= req_age;
      end
      pre_ok_ff     <= pre_ok_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_pidx_ff   <= res_pidx_in;
      res_slot_ff   <= res_slot_in;
      res_new_ff    <= res_new_in;
      res_cx_ff     <= res_cx_in;
      res_cy_ff     <= res_cy_in;
      if (out_load) begin
         o_status_ff <= res_status_ff;
         o_pidx_ff   <= pidx_wide[PIDX_OUT_W-1:0];
         o_slot_ff   <= res_slot_ff;
         o_new_ff    <= res_new_ff;
         o_cx_ff     <= res_cx_ff;
         o_cy_ff     <= res_cy_ff;
         o_x_ff      <= px_ff;
         o_y_ff      <= py_ff;
         o_z_ff      <= pz_ff;
         o_int_ff    <= int_ff;
         o_age_ff    <= age_ff;
      end
   end

   // cell map: {epoch, pillar}; an entry is live only under the current epoch
   always_ff @(posedge clock) begin
      if (map_we) begin
         cell_map[map_waddr] <= map_wdata;
      end
      map_q <= cell_map[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         pillar_cnt[cnt_waddr] <= cnt_wdata;
      end
      cnt_q <= pillar_cnt[cnt_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_pillar_index  = o_pidx_ff;
   assign rsp_slot          = o_slot_ff;
   assign rsp_new_pillar    = o_new_ff;
   assign rsp_cell_x        = o_cx_ff;
   assign rsp_cell_y        = o_cy_ff;
   assign rsp_out_x         = o_x_ff;
   assign rsp_out_y         = o_y_ff;
   assign rsp_out_z         = o_z_ff;
   assign rsp_out_intensity = o_int_ff;
   assign rsp_out_age       = o_age_ff;

   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(total_ff) <= CAP_C)
      else $error("pillar count beyond capacity");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   a_stored_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STORED |-> rsp_slot < slimit_ff)
      else $error("stored slot beyond slot limit");

   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OUT_OF_RANGE |->
         rsp_pillar_index == '0 && !rsp_new_pillar && rsp_cell_x == '0)
      else $error("dropped point carries pillar data");

   a_divs_aligned: assert property (@(posedge clock) disable iff (reset)
      div_done_x == div_done_y)
      else $error("cell dividers out of step");

endmodule
